@@ hdl/sv39ptw_pkg.sv @@
// sv39ptw_pkg: shared types, codes and fixed widths of the sv39 page-table walker
// used by the interfaces and by every module of the walker; depends on nothing
`default_nettype none

package sv39ptw_pkg;

  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned SLOT_W           = 9;
  localparam int unsigned VA_W             = 39;
  localparam int unsigned PA_W             = 56;
  localparam int unsigned CNT_W            = 21;
  localparam int unsigned PERM_W           = 10;
  localparam int unsigned PPN_W            = 44;
  localparam int unsigned PTE_W            = 64;
  localparam int unsigned PAGE_OUT_W       = 6;
  localparam int unsigned STATUS_W         = 3;
  localparam int unsigned ACTION_W         = 2;
  localparam int unsigned PAGE_OFS_W       = 12;
  // page number of a walking address, one bit of headroom for a run past the top
  localparam int unsigned VPN_W            = 28;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ALLOC  = 2'd1,
    ACT_MAP    = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMAP    = 3'd3,
    ST_UNMAPPED = 3'd4,
    ST_OUTSIDE  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_RD,
    S_EVAL,
    S_LINK,
    S_RESULT
  } seq_state_e;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [PPN_W-1:0]   a;
    logic [PPN_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [PPN_W-1:0]   sum;
    logic               outside;
  } alu_rsp_t;

  typedef struct packed {
    status_e                status;
    logic [PAGE_OUT_W-1:0]  page;
    logic [SLOT_W-1:0]      slot;
    logic [PTE_W-1:0]       entry;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/sv39ptw_intf.sv @@
// sv39ptw channel interfaces: request, response and configuration write
// payload widths come from sv39ptw_pkg
`default_nettype none

interface sv39ptw_req_if;
  logic                               valid;
  logic                               ready;
  logic [sv39ptw_pkg::ACTION_W-1:0]   action;
  logic [sv39ptw_pkg::VA_W-1:0]       virt_addr;
  logic [sv39ptw_pkg::PA_W-1:0]       phys_addr;
  logic [sv39ptw_pkg::CNT_W-1:0]      page_count;
  logic [sv39ptw_pkg::PERM_W-1:0]     permissions;

  modport source (output valid, action, virt_addr, phys_addr, page_count, permissions,
                  input ready);
  modport sink   (input valid, action, virt_addr, phys_addr, page_count, permissions,
                  output ready);
endinterface

interface sv39ptw_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [sv39ptw_pkg::STATUS_W-1:0]   status;
  logic [sv39ptw_pkg::PAGE_OUT_W-1:0] leaf_page;
  logic [sv39ptw_pkg::SLOT_W-1:0]     leaf_slot;
  logic [sv39ptw_pkg::PTE_W-1:0]      leaf_entry;

  modport source (output valid, status, leaf_page, leaf_slot, leaf_entry, input ready);
  modport sink   (input valid, status, leaf_page, leaf_slot, leaf_entry, output ready);
endinterface

interface sv39ptw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sv39ptw_pkg::PPN_W-1:0]      table_base_ppn;

  modport source (output valid, table_base_ppn, input ready);
  modport sink   (input valid, table_base_ppn, output ready);
endinterface

`default_nettype wire

@@ hdl/sv39ptw_ptr_unit.sv @@
// sv39ptw_ptr_unit: shared 44-bit add/subtract unit for pointer conversion
// subtract gives the store page of a pointer, add builds a pointer; uses sv39ptw_pkg
`default_nettype none

module sv39ptw_ptr_unit #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  sv39ptw_pkg::alu_req_t req_i,
  output sv39ptw_pkg::alu_rsp_t rsp_o
);

  logic [sv39ptw_pkg::PPN_W-1:0] b_eff;
  logic                          is_sub;

  assign is_sub = (req_i.op == sv39ptw_pkg::OP_SUB);
  assign b_eff  = is_sub ? ~req_i.b : req_i.b;

  // one adder, wraps modulo 2^44
  assign rsp_o.sum     = req_i.a + b_eff + sv39ptw_pkg::PPN_W'(is_sub);
  assign rsp_o.outside = (rsp_o.sum >= sv39ptw_pkg::PPN_W'(TABLE_PAGES));

endmodule

`default_nettype wire

@@ hdl/sv39ptw_store.sv @@
// sv39ptw_store: table store memory, one write and one registered read per cycle
// entries are 64-bit page-table entries; uses sv39ptw_pkg
`default_nettype none

module sv39ptw_store #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [ADDR_W-1:0]               waddr_i,
  input  logic [sv39ptw_pkg::PTE_W-1:0]   wdata_i,
  input  logic                            re_i,
  input  logic [ADDR_W-1:0]               raddr_i,
  output logic [sv39ptw_pkg::PTE_W-1:0]   rdata_o
);

  localparam int unsigned DEPTH  = TABLE_PAGES * sv39ptw_pkg::ENTRIES_PER_PAGE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [sv39ptw_pkg::PTE_W-1:0] mem [DEPTH];
  logic [sv39ptw_pkg::PTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/sv39ptw_seq.sv @@
// sv39ptw_seq: sequencer of the walker, steps the levels, allocation, clearing and map runs
// drives the table store and the shared pointer unit; uses sv39ptw_pkg and sv39ptw_req_if
`default_nettype none

module sv39ptw_seq #(
  parameter int unsigned TABLE_PAGES   = 64,
  parameter int unsigned VA_LIMIT_BITS = 38
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sv39ptw_req_if.sink                     req_i,
  input  logic [sv39ptw_pkg::PPN_W-1:0]   base_ppn_i,
  output sv39ptw_pkg::alu_req_t           alu_req_o,
  input  sv39ptw_pkg::alu_rsp_t           alu_rsp_i,
  output logic                            mem_we_o,
  output logic [ADDR_W-1:0]               mem_waddr_o,
  output logic [sv39ptw_pkg::PTE_W-1:0]   mem_wdata_o,
  output logic                            mem_re_o,
  output logic [ADDR_W-1:0]               mem_raddr_o,
  input  logic [sv39ptw_pkg::PTE_W-1:0]   mem_rdata_i,
  output logic                            res_valid_o,
  output sv39ptw_pkg::res_t               res_o,
  input  logic                            res_ready_i
);

  localparam int unsigned PW     = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned ADDR_W = PW + sv39ptw_pkg::SLOT_W;
  localparam int unsigned NFP_W  = $clog2(TABLE_PAGES + 1);
  localparam int unsigned SW     = sv39ptw_pkg::SLOT_W;
  localparam int unsigned VPN_W  = sv39ptw_pkg::VPN_W;
  localparam int unsigned PPN_W  = sv39ptw_pkg::PPN_W;
  localparam int unsigned PTE_W  = sv39ptw_pkg::PTE_W;

  sv39ptw_pkg::seq_state_e state_q, state_d;
  sv39ptw_pkg::status_e    status_q, status_d;

  logic                          alloc_q, alloc_d;
  logic                          map_q, map_d;
  logic [VPN_W-1:0]              vpn_q, vpn_d;
  logic [PPN_W-1:0]              ppn_q, ppn_d;
  logic [sv39ptw_pkg::PERM_W-1:0] perm_q, perm_d;
  logic [sv39ptw_pkg::CNT_W-1:0] remain_q, remain_d;
  logic [1:0]                    level_q, level_d;
  logic [PW-1:0]                 page_q, page_d;
  logic [PW-1:0]                 parent_page_q, parent_page_d;
  logic [SW-1:0]                 parent_slot_q, parent_slot_d;
  logic [PW-1:0]                 fresh_q, fresh_d;
  logic [NFP_W-1:0]              nfp_q, nfp_d;
  logic [PW-1:0]                 clr_page_q, clr_page_d;
  logic [SW-1:0]                 clr_slot_q, clr_slot_d;
  logic                          clr_all_q, clr_all_d;
  logic [PW-1:0]                 res_page_q, res_page_d;
  logic [SW-1:0]                 res_slot_q, res_slot_d;
  logic [PTE_W-1:0]              res_entry_q, res_entry_d;

  logic [SW-1:0]                 cur_slot;
  logic [PTE_W-1:0]              leaf_pte;
  logic                          va_bad;

  always_comb begin
    case (level_q)
      2'd2:    cur_slot = vpn_q[3*SW-1:2*SW];
      2'd1:    cur_slot = vpn_q[2*SW-1:SW];
      default: cur_slot = vpn_q[SW-1:0];
    endcase
  end

  assign va_bad   = (vpn_q[VPN_W-1:VA_LIMIT_BITS-sv39ptw_pkg::PAGE_OFS_W] != '0);
  assign leaf_pte = {10'd0, ppn_q, perm_q[sv39ptw_pkg::PERM_W-1:1], 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sv39ptw_pkg::S_CLEAR;
      nfp_q      <= NFP_W'(1);
      clr_page_q <= '0;
      clr_slot_q <= '0;
      clr_all_q  <= 1'b1;
    end else begin
      state_q    <= state_d;
      nfp_q      <= nfp_d;
      clr_page_q <= clr_page_d;
      clr_slot_q <= clr_slot_d;
      clr_all_q  <= clr_all_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q      <= status_d;
    alloc_q       <= alloc_d;
    map_q         <= map_d;
    vpn_q         <= vpn_d;
    ppn_q         <= ppn_d;
    perm_q        <= perm_d;
    remain_q      <= remain_d;
    level_q       <= level_d;
    page_q        <= page_d;
    parent_page_q <= parent_page_d;
    parent_slot_q <= parent_slot_d;
    fresh_q       <= fresh_d;
    res_page_q    <= res_page_d;
    res_slot_q    <= res_slot_d;
    res_entry_q   <= res_entry_d;
  end

  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    alloc_d       = alloc_q;
    map_d         = map_q;
    vpn_d         = vpn_q;
    ppn_d         = ppn_q;
    perm_d        = perm_q;
    remain_d      = remain_q;
    level_d       = level_q;
    page_d        = page_q;
    parent_page_d = parent_page_q;
    parent_slot_d = parent_slot_q;
    fresh_d       = fresh_q;
    nfp_d         = nfp_q;
    clr_page_d    = clr_page_q;
    clr_slot_d    = clr_slot_q;
    clr_all_d     = clr_all_q;
    res_page_d    = res_page_q;
    res_slot_d    = res_slot_q;
    res_entry_d   = res_entry_q;

    req_i.ready   = 1'b0;
    res_valid_o   = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = {page_q, cur_slot};
    mem_wdata_o   = leaf_pte;
    mem_re_o      = 1'b0;
    mem_raddr_o   = {page_q, cur_slot};
    alu_req_o.op  = sv39ptw_pkg::OP_SUB;
    alu_req_o.a   = mem_rdata_i[PPN_W+9:10];
    alu_req_o.b   = base_ppn_i;

    case (state_q)
      sv39ptw_pkg::S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = {clr_page_q, clr_slot_q};
        mem_wdata_o = '0;
        clr_slot_d  = clr_slot_q + SW'(1);
        if (clr_slot_q == '1) begin
          if (clr_all_q && (clr_page_q != PW'(TABLE_PAGES - 1))) begin
            clr_page_d = clr_page_q + PW'(1);
          end else if (clr_all_q) begin
            clr_all_d = 1'b0;
            state_d   = sv39ptw_pkg::S_IDLE;
          end else begin
            state_d = sv39ptw_pkg::S_LINK;
          end
        end
      end

      sv39ptw_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          map_d       = (req_i.action == sv39ptw_pkg::ACT_MAP);
          alloc_d     = (req_i.action == sv39ptw_pkg::ACT_MAP) ||
                        (req_i.action == sv39ptw_pkg::ACT_ALLOC);
          vpn_d       = {1'b0, req_i.virt_addr[sv39ptw_pkg::VA_W-1:sv39ptw_pkg::PAGE_OFS_W]};
          ppn_d       = req_i.phys_addr[sv39ptw_pkg::PA_W-1:sv39ptw_pkg::PAGE_OFS_W];
          perm_d      = req_i.permissions;
          remain_d    = req_i.page_count;
          status_d    = sv39ptw_pkg::ST_OK;
          res_page_d  = '0;
          res_slot_d  = '0;
          res_entry_d = '0;
          // empty map run writes nothing
          if ((req_i.action == sv39ptw_pkg::ACT_MAP) && (req_i.page_count == '0)) begin
            state_d = sv39ptw_pkg::S_RESULT;
          end else begin
            state_d = sv39ptw_pkg::S_START;
          end
        end
      end

      sv39ptw_pkg::S_START: begin
        level_d = 2'd2;
        page_d  = '0;
        if (va_bad) begin
          status_d    = sv39ptw_pkg::ST_RANGE;
          res_page_d  = '0;
          res_slot_d  = '0;
          res_entry_d = '0;
          state_d     = sv39ptw_pkg::S_RESULT;
        end else begin
          state_d = sv39ptw_pkg::S_RD;
        end
      end

      sv39ptw_pkg::S_RD: begin
        mem_re_o = 1'b1;
        state_d  = sv39ptw_pkg::S_EVAL;
      end

      sv39ptw_pkg::S_EVAL: begin
        if (level_q != 2'd0) begin
          if (mem_rdata_i[0]) begin
            // valid pointer, whatever its r/w/x bits
            if (alu_rsp_i.outside) begin
              status_d = sv39ptw_pkg::ST_OUTSIDE;
            end else begin
              page_d  = alu_rsp_i.sum[PW-1:0];
              level_d = level_q - 2'd1;
              state_d = sv39ptw_pkg::S_RD;
            end
          end else if (!alloc_q) begin
            status_d = sv39ptw_pkg::ST_UNMAPPED;
          end else if (nfp_q >= NFP_W'(TABLE_PAGES)) begin
            status_d = sv39ptw_pkg::ST_FULL;
          end else begin
            fresh_d       = nfp_q[PW-1:0];
            nfp_d         = nfp_q + NFP_W'(1);
            parent_page_d = page_q;
            parent_slot_d = cur_slot;
            clr_page_d    = nfp_q[PW-1:0];
            clr_slot_d    = '0;
            clr_all_d     = 1'b0;
            state_d       = sv39ptw_pkg::S_CLEAR;
          end
          if (mem_rdata_i[0] ? alu_rsp_i.outside
                             : (!alloc_q || (nfp_q >= NFP_W'(TABLE_PAGES)))) begin
            res_page_d  = '0;
            res_slot_d  = '0;
            res_entry_d = '0;
            state_d     = sv39ptw_pkg::S_RESULT;
          end
        end else begin
          res_page_d = page_q;
          res_slot_d = cur_slot;
          if (!map_q) begin
            status_d    = sv39ptw_pkg::ST_OK;
            res_entry_d = mem_rdata_i;
            state_d     = sv39ptw_pkg::S_RESULT;
          end else if (mem_rdata_i[0]) begin
            status_d    = sv39ptw_pkg::ST_REMAP;
            res_entry_d = mem_rdata_i;
            state_d     = sv39ptw_pkg::S_RESULT;
          end else begin
            mem_we_o    = 1'b1;
            res_entry_d = leaf_pte;
            status_d    = sv39ptw_pkg::ST_OK;
            vpn_d       = vpn_q + VPN_W'(1);
            ppn_d       = ppn_q + PPN_W'(1);
            remain_d    = remain_q - sv39ptw_pkg::CNT_W'(1);
            if (remain_q == sv39ptw_pkg::CNT_W'(1)) begin
              state_d = sv39ptw_pkg::S_RESULT;
            end else begin
              state_d = sv39ptw_pkg::S_START;
            end
          end
        end
      end

      sv39ptw_pkg::S_LINK: begin
        // fresh page is zeroed, now hook it into the parent entry
        alu_req_o.op = sv39ptw_pkg::OP_ADD;
        alu_req_o.a  = base_ppn_i;
        alu_req_o.b  = PPN_W'(fresh_q);
        mem_we_o     = 1'b1;
        mem_waddr_o  = {parent_page_q, parent_slot_q};
        mem_wdata_o  = {10'd0, alu_rsp_i.sum, 10'd1};
        page_d       = fresh_q;
        level_d      = level_q - 2'd1;
        state_d      = sv39ptw_pkg::S_RD;
      end

      sv39ptw_pkg::S_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = sv39ptw_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sv39ptw_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o.status = status_q;
  assign res_o.page   = sv39ptw_pkg::PAGE_OUT_W'(res_page_q);
  assign res_o.slot   = res_slot_q;
  assign res_o.entry  = res_entry_q;

endmodule

`default_nettype wire

@@ hdl/sv39_page_table_walker_core.sv @@
// sv39_page_table_walker_core: top level of the sv39 page-table walker
// holds the base register and the result register; instantiates sv39ptw_seq,
// sv39ptw_store and sv39ptw_ptr_unit; uses sv39ptw_pkg and the sv39ptw interfaces
//
// usage:
//   cfg_i  - write channel for table_base_ppn, always ready, written while idle
//   req_i  - one transaction per operation: lookup, allocating walk or map run
//   rsp_o  - exactly one transaction per request: status and the leaf entry reached
// timing:
//   the sequencer takes one request at a time and drops req_i.ready until done
//   lookup: start, then three read/evaluate pairs on the single store port
//   each missing table adds a zeroing sweep of the fresh page plus the link write
//   map run: a walk and a leaf write per page, plus table allocations
//   the store has one write and one registered read port
// reset:
//   after rst_ni all TABLE_PAGES * 512 store entries are swept to zero, during which
//   req_i.ready stays low; cfg_i is taken as ever
// stalls:
//   a result sits in the output register until rsp_o.ready; the next request is
//   accepted meanwhile and waits only when its own result is ready to leave
`default_nettype none

module sv39_page_table_walker_core #(
  parameter int unsigned TABLE_PAGES   = 64,
  parameter int unsigned VA_LIMIT_BITS = 38
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sv39ptw_cfg_if.sink   cfg_i,
  sv39ptw_req_if.sink   req_i,
  sv39ptw_rsp_if.source rsp_o
);

  localparam int unsigned PW     = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned ADDR_W = PW + sv39ptw_pkg::SLOT_W;

  logic [sv39ptw_pkg::PPN_W-1:0] base_q;
  sv39ptw_pkg::alu_req_t         alu_req;
  sv39ptw_pkg::alu_rsp_t         alu_rsp;
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_waddr;
  logic [sv39ptw_pkg::PTE_W-1:0] mem_wdata;
  logic                          mem_re;
  logic [ADDR_W-1:0]             mem_raddr;
  logic [sv39ptw_pkg::PTE_W-1:0] mem_rdata;
  logic                          res_valid;
  logic                          res_ready;
  sv39ptw_pkg::res_t             res;
  logic                          out_valid_q;
  sv39ptw_pkg::res_t             out_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_i.valid) begin
      base_q <= cfg_i.table_base_ppn;
    end
  end

  sv39ptw_ptr_unit #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_ptr_unit (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  sv39ptw_store #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sv39ptw_seq #(
    .TABLE_PAGES   (TABLE_PAGES),
    .VA_LIMIT_BITS (VA_LIMIT_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .base_ppn_i  (base_q),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register frees the sequencer while the receiver stalls
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.leaf_page  = out_q.page;
  assign rsp_o.leaf_slot  = out_q.slot;
  assign rsp_o.leaf_entry = out_q.entry;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// tb_top: self-checking bench for sv39_page_table_walker_core, with a directed table
// followed by random walks and map runs. Every response is checked against an in-bench model or a planned result.
// depends on sv39ptw_pkg, the sv39ptw channel interfaces and the walker core
`timescale 1ns / 100ps

module tb_top;
  import sv39ptw_pkg::*;

  localparam int unsigned TABLE_PAGES     = 64;
  localparam int unsigned VA_LIMIT_BITS   = 38;
  localparam int unsigned PHASE_ITEMS     = 195;
  localparam int unsigned QUIET_LIMIT     = 200000;
  localparam int unsigned TAIL_CYCLES     = 20;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VA_W-1:0]     va;
    logic [PA_W-1:0]     pa;
    logic [CNT_W-1:0]    count;
    logic [PERM_W-1:0]   perm;
  } req_item_t;

  typedef enum logic {
    ROW_REQUEST,
    ROW_BASE
  } row_kind_e;

  typedef struct {
    row_kind_e        kind;
    req_item_t        item;
    bit               typed;
    res_t             want;
    bit [PPN_W-1:0]   base;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  sv39ptw_cfg_if cfg_if ();
  sv39ptw_req_if req_if ();
  sv39ptw_rsp_if rsp_if ();

  sv39_page_table_walker_core #(
    .TABLE_PAGES  (TABLE_PAGES),
    .VA_LIMIT_BITS(VA_LIMIT_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // model of the table store, the bump allocator and the base register
  bit [PTE_W-1:0] walk_store [TABLE_PAGES*ENTRIES_PER_PAGE];
  int unsigned    pages_claimed = 1;
  bit [PPN_W-1:0] table_base;

  res_t        due_results [$];
  plan_row_t   plan [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned base_writes;
  int unsigned status_seen [8];
  int unsigned action_seen [4];
  int unsigned src_calm;
  int unsigned sink_calm;
  int unsigned quiet_cycles;
  bit [7:0]    l2_pool [4];
  bit [8:0]    l1_pool [4];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // walks levels 2 and 1, claiming fresh tables when grow is set
  function automatic status_e table_walk(input bit [63:0] va, input bit grow,
                                         output int unsigned leaf_pg);
    int unsigned    pg;
    int unsigned    idx;
    int unsigned    fresh;
    int             lvl;
    int unsigned    i;
    bit [PTE_W-1:0] e;
    bit [PPN_W-1:0] rel;
    bit [PPN_W-1:0] link_ppn;
    pg = 0;
    leaf_pg = 0;
    if ((va >> VA_LIMIT_BITS) != 0) return ST_RANGE;
    for (lvl = 2; lvl > 0; lvl--) begin
      idx = pg * ENTRIES_PER_PAGE + va[PAGE_OFS_W + SLOT_W*lvl +: SLOT_W];
      e = walk_store[idx];
      if (e[0]) begin
        // any valid entry above level 0 is a pointer, whatever its r/w/x bits
        rel = e[PPN_W+9:10] - table_base;
        if (rel >= TABLE_PAGES) return ST_OUTSIDE;
        pg = rel;
      end else begin
        if (!grow) return ST_UNMAPPED;
        if (pages_claimed >= TABLE_PAGES) return ST_FULL;
        fresh = pages_claimed;
        pages_claimed++;
        for (i = 0; i < ENTRIES_PER_PAGE; i++) walk_store[fresh*ENTRIES_PER_PAGE + i] = '0;
        link_ppn = table_base + fresh;
        walk_store[idx] = {10'd0, link_ppn, 10'd1};
        pg = fresh;
      end
    end
    leaf_pg = pg;
    return ST_OK;
  endfunction

  function automatic res_t apply_request(input req_item_t it);
    res_t           r;
    bit [63:0]      a;
    bit [PPN_W-1:0] ppn;
    int unsigned    lp;
    int unsigned    n;
    int unsigned    idx;
    bit [SLOT_W-1:0] ls;
    bit             stop;
    status_e        st;
    r = '0;
    if (it.action == ACT_MAP) begin
      a = {25'd0, it.va};
      a[PAGE_OFS_W-1:0] = '0;
      ppn = it.pa[PAGE_OFS_W +: PPN_W];
      n = 0;
      stop = 1'b0;
      while (n < it.count && !stop) begin
        st = table_walk(a, 1'b1, lp);
        r.status = st;
        if (st != ST_OK) begin
          r.page = '0;
          r.slot = '0;
          r.entry = '0;
          stop = 1'b1;
        end else begin
          ls = a[PAGE_OFS_W +: SLOT_W];
          idx = lp * ENTRIES_PER_PAGE + ls;
          r.page = PAGE_OUT_W'(lp);
          r.slot = ls;
          if (walk_store[idx][0]) begin
            // remap leaves the valid entry as found
            r.status = ST_REMAP;
            r.entry = walk_store[idx];
            stop = 1'b1;
          end else begin
            walk_store[idx] = {10'd0, ppn, it.perm | 10'd1};
            r.entry = walk_store[idx];
            a += 64'd4096;
            ppn++;
            n++;
          end
        end
      end
    end else begin
      // the spare action code walks like a lookup
      st = table_walk({25'd0, it.va}, it.action == ACT_ALLOC, lp);
      r.status = st;
      if (st == ST_OK) begin
        r.page = PAGE_OUT_W'(lp);
        r.slot = it.va[PAGE_OFS_W +: SLOT_W];
        r.entry = walk_store[lp * ENTRIES_PER_PAGE + r.slot];
      end
    end
    return r;
  endfunction

  // idle cycles before the next transaction, with occasional stretches of none
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic void plan_request(input logic [ACTION_W-1:0] action,
                                       input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
                                       input logic [CNT_W-1:0] count,
                                       input logic [PERM_W-1:0] perm,
                                       input bit typed, input status_e st);
    plan_row_t row;
    row.kind = ROW_REQUEST;
    row.item = '{action: action, va: va, pa: pa, count: count, perm: perm};
    row.typed = typed;
    row.want = '0;
    row.want.status = st;
    row.base = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_base(input bit [PPN_W-1:0] value);
    plan_row_t row;
    row.kind = ROW_BASE;
    row.item = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.base = value;
    plan.push_back(row);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch on result %0d: %s", results_seen, what);
  endtask

  task automatic send_request(input req_item_t it, input bit typed, input res_t want);
    int unsigned gap;
    res_t        predicted;
    gap = pick_gap(src_calm);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= it.action;
    req_if.virt_addr   <= it.va;
    req_if.phys_addr   <= it.pa;
    req_if.page_count  <= it.count;
    req_if.permissions <= it.perm;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    predicted = apply_request(it);
    due_results.push_back(typed ? want : predicted);
    action_seen[it.action]++;
  endtask

  // register writes only once every response is back
  task automatic write_table_base(input bit [PPN_W-1:0] value);
    req_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    cfg_if.valid          <= 1'b1;
    cfg_if.table_base_ppn <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    table_base = value;
    cfg_if.valid <= 1'b0;
    base_writes++;
  endtask

  initial begin : stimulus
    req_item_t   it;
    plan_row_t   row;
    int unsigned p;
    int unsigned k;
    int unsigned pick;
    bit [PPN_W-1:0] phase_base;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.table_base_ppn = '0;
    req_if.valid = 1'b0;
    req_if.action = '0;
    req_if.virt_addr = '0;
    req_if.phys_addr = '0;
    req_if.page_count = '0;
    req_if.permissions = '0;
    l2_pool = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(2, 254))};
    l1_pool = '{9'd0, 9'd1, 9'd511, 9'($urandom_range(2, 510))};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    plan_base('0);
    plan_request(ACT_LOOKUP, 39'h0, 56'h0, 21'd1, 10'h0, 1'b1, ST_UNMAPPED);
    plan_request(ACT_SPARE, 39'h3F_FFFF_FFFF, 56'h0, 21'd1, 10'h0, 1'b1, ST_UNMAPPED);
    plan_request(ACT_LOOKUP, 39'h7F_FFFF_FFFF, 56'h0, 21'd1, 10'h0, 1'b1, ST_RANGE);
    plan_request(ACT_ALLOC, 39'h0, 56'h0, 21'd1, 10'h0, 1'b0, ST_OK);
    plan_request(ACT_MAP, 39'h0, 56'hFF_FFFF_FFFF_FFFF, 21'd1, 10'h3FF, 1'b0, ST_OK);
    // remap on the first page, so the large count costs nothing
    plan_request(ACT_MAP, 39'h0, 56'h0, 21'h10_0000, 10'h0, 1'b0, ST_OK);
    // unaligned start, physical page number wraps on the third page
    plan_request(ACT_MAP, 39'h1FFF, 56'hFF_FFFF_FFFF_EABC, 21'd3, 10'h2AA, 1'b0, ST_OK);
    plan_request(ACT_MAP, 39'h5000, 56'h12_3456_7800_0000, 21'd0, 10'h155, 1'b1, ST_OK);
    // runs off the top of the address space after two pages
    plan_request(ACT_MAP, 39'h3F_FFFF_E000, 56'h12_3456_789A_B000, 21'd4, 10'h155, 1'b1,
                 ST_RANGE);
    plan_request(ACT_MAP, 39'h40_0000_0000, 56'h0, 21'h0F_FFFF, 10'h3FF, 1'b1, ST_RANGE);
    plan_request(ACT_LOOKUP, 39'h3F_FFFF_F000, 56'h0, 21'd1, 10'h0, 1'b0, ST_OK);
    plan_request(ACT_LOOKUP, 39'h00_0020_0000, 56'h0, 21'd1, 10'h0, 1'b1, ST_UNMAPPED);
    plan_request(ACT_ALLOC, 39'h00_0020_0000, 56'h0, 21'd1, 10'h0, 1'b0, ST_OK);
    plan_request(ACT_LOOKUP, 39'h3000, 56'h0, 21'd1, 10'h0, 1'b0, ST_OK);
    // top base: old pointers alias other store pages, new ones wrap
    plan_base(44'hFFF_FFFF_FFFF);
    plan_request(ACT_LOOKUP, 39'h0, 56'h0, 21'd1, 10'h0, 1'b0, ST_OK);
    plan_request(ACT_ALLOC, 39'h00_4000_0000, 56'h0, 21'd1, 10'h0, 1'b0, ST_OK);
    plan_request(ACT_MAP, 39'h00_4000_2000, 56'h80_0000_0000_0000, 21'd2, 10'h0C3, 1'b0,
                 ST_OK);
    plan_base(44'h800_0000_0000);
    plan_request(ACT_LOOKUP, 39'h0, 56'h0, 21'd1, 10'h0, 1'b1, ST_OUTSIDE);
    plan_request(ACT_ALLOC, 39'h00_4000_0000, 56'h0, 21'd1, 10'h0, 1'b1, ST_OUTSIDE);
    plan_base('0);
    plan_request(ACT_LOOKUP, 39'h2000, 56'h0, 21'd1, 10'h0, 1'b0, ST_OK);
    plan_request(ACT_MAP, 39'h00_4000_2000, 56'h00_0000_0001_0000, 21'd1, 10'h3FE, 1'b0,
                 ST_OK);
    plan_request(ACT_LOOKUP, 39'h00_4000_2000, 56'h0, 21'd1, 10'h0, 1'b0, ST_OK);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_BASE) write_table_base(row.base);
      else send_request(row.item, row.typed, row.want);
    end

    for (p = 0; p < 5; p++) begin
      case (p)
        1:       phase_base = '1;
        2:       phase_base = PPN_W'($urandom_range(1, 8));
        3:       phase_base = PPN_W'({$urandom, $urandom});
        default: phase_base = '0;
      endcase
      write_table_base(phase_base);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        it.pa = PA_W'({$urandom, $urandom});
        it.perm = PERM_W'($urandom);
        if (pick < 15) begin
          // noise: anywhere in the space, mostly fresh tables, so the store fills up
          it.action = ACTION_W'($urandom_range(0, 3));
          it.va = {$urandom_range(0, 3) == 0, 38'({$urandom, $urandom})};
          it.count = it.va[VA_W-1] ? CNT_W'($urandom_range(1, 1 << 20))
                                   : CNT_W'($urandom_range(0, 4));
        end else begin
          pick = $urandom_range(0, 99);
          it.action = (pick < 35) ? ACT_LOOKUP : (pick < 50) ? ACT_ALLOC :
                      (pick < 95) ? ACT_MAP : ACT_SPARE;
          it.va = {1'b0, l2_pool[$urandom_range(0, 3)], l1_pool[$urandom_range(0, 3)],
                   9'($urandom), 12'($urandom)};
          it.count = ($urandom_range(0, 19) == 0) ? CNT_W'($urandom_range(1, 600))
                                                 : CNT_W'($urandom_range(1, 8));
        end
        send_request(it, 1'b0, '0);
      end
    end
    req_if.valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d requests: %0d lookups, %0d allocating walks, %0d map runs, %0d spare code; %0d base writes",
             action_seen[0] + action_seen[1] + action_seen[2] + action_seen[3],
             action_seen[0], action_seen[1], action_seen[2], action_seen[3], base_writes);
    $display("responses: ok %0d, range %0d, full %0d, remap %0d, unmapped %0d, outside %0d; %0d of %0d pages in use",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5], pages_claimed, TABLE_PAGES);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : response_sink
    int unsigned gap;
    res_t        want;
    rsp_if.ready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = pick_gap(sink_calm);
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      results_seen++;
      status_seen[rsp_if.status]++;
      if (due_results.size() == 0) begin
        flag_mismatch("response transaction with no request outstanding");
      end else begin
        want = due_results.pop_front();
        if (rsp_if.status !== want.status)
          flag_mismatch($sformatf("status expected %0d got %0d", want.status, rsp_if.status));
        if (rsp_if.leaf_page !== want.page)
          flag_mismatch($sformatf("leaf_page expected %0d got %0d", want.page,
                                  rsp_if.leaf_page));
        if (rsp_if.leaf_slot !== want.slot)
          flag_mismatch($sformatf("leaf_slot expected %0d got %0d", want.slot,
                                  rsp_if.leaf_slot));
        if (rsp_if.leaf_entry !== want.entry)
          flag_mismatch($sformatf("leaf_entry expected %h got %h", want.entry,
                                  rsp_if.leaf_entry));
      end
    end
  end

  // a stretch with no transaction on any channel ends the run
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
               quiet_cycles, due_results.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
